>>> design/pid_heading_corrector_unit_assert.svh
// Assertion macros for the PID heading corrector checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PID_HEADING_CORRECTOR_UNIT_ASSERT_SVH
`define PID_HEADING_CORRECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PHC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/phc_pkg.sv
// Shared types, widths and constants of the PID heading corrector.
// No dependencies; imported by every design module.
package phc_pkg;

    localparam int MOTOR_COUNT = 4;

    localparam int SPEED_W  = 10;
    localparam int HEAD_W   = 10;
    localparam int DT_W     = 16;
    localparam int ERR_W    = 11;
    localparam int OUT_W    = 11;
    localparam int CFG_W    = 15;
    localparam int GAIN_W   = 8;
    localparam int LIMIT_W  = 15;
    localparam int MARGIN_W = 9;
    localparam int BOUND_W  = 12;
    localparam int PROD_W   = 27;
    localparam int MAG_W    = 26;
    localparam int QUOT_W   = 22;
    localparam int QX_W     = 23;
    localparam int KSUM_W   = 24;
    localparam int ACC_W    = 16;
    localparam int PTERM_W  = 19;
    localparam int DIFF_W   = 12;
    localparam int DTERM_W  = 20;
    localparam int I100_W   = 10;
    localparam int SUM_W    = 22;

    localparam logic signed [BOUND_W-1:0] SPEED_FLOOR = -12'sd450;
    localparam logic signed [BOUND_W-1:0] SPEED_CEIL  = 12'sd450;

    // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT, exact for any 32-bit x
    localparam int              RECIP5_SHIFT = 34;
    localparam logic [31:0]     RECIP5       = 32'hCCCC_CCCD;
    localparam int              Q5_PROD_W    = MAG_W - 2 + 32;
    // floor(x / 100) = (x * RECIP100) >> RECIP100_SHIFT, exact for x < 43690
    localparam int              RECIP100_SHIFT = 19;
    localparam logic [12:0]     RECIP100       = 13'd5243;
    localparam int              Q100_PROD_W    = ACC_W - 1 + 13;

    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 8'd3;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 8'd10;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST      = 15'd10000;
    localparam logic [MARGIN_W-1:0] MARGIN_RST     = 9'd93;

    typedef enum logic [1:0] {
        CFG_PROP_GAIN      = 2'd0,
        CFG_DERIV_GAIN     = 2'd1,
        CFG_INTEGRAL_LIMIT = 2'd2,
        CFG_DRIVE_MARGIN   = 2'd3
    } cfg_idx_t;

    typedef logic signed [SPEED_W-1:0] speed_t;

    // Control bits that steer the integral update.
    typedef struct packed {
        logic err_zero;
        logic rem_nz;
        logic neg;
    } integ_ctl_t;

endpackage

>>> design/phc_speed_bounds.sv
// Clamp window of the correction from the motor speeds and the drive margin.
// Depends on phc_pkg.
module phc_speed_bounds (
    input  phc_pkg::speed_t                        speed [phc_pkg::MOTOR_COUNT],
    input  logic [phc_pkg::MARGIN_W-1:0]           margin,
    output logic signed [phc_pkg::BOUND_W-1:0]     hi_bound,
    output logic signed [phc_pkg::BOUND_W-1:0]     lo_bound
);
    import phc_pkg::*;

    logic signed [BOUND_W-1:0] max_speed;
    logic signed [BOUND_W-1:0] min_speed;
    logic signed [BOUND_W-1:0] margin_s;

    // Seed with the nominal limits, then take every speed as given.
    always_comb
    begin
        max_speed = SPEED_FLOOR;
        min_speed = SPEED_CEIL;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            if (BOUND_W'(speed[i]) < min_speed)
            begin
                min_speed = BOUND_W'(speed[i]);
            end
            if (max_speed < BOUND_W'(speed[i]))
            begin
                max_speed = BOUND_W'(speed[i]);
            end
        end
    end

    assign margin_s = $signed({{(BOUND_W-MARGIN_W){1'b0}}, margin});
    assign hi_bound = margin_s - max_speed;
    assign lo_bound = -margin_s - min_speed;

endmodule

>>> design/phc_integral.sv
// Integral accumulator: exact truncating divide-by-20 recombination and clamp.
// Depends on phc_pkg.
module phc_integral (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                upd,
    input  phc_pkg::integ_ctl_t                 ctl,
    input  logic signed [phc_pkg::QX_W-1:0]     quot,
    input  logic [phc_pkg::LIMIT_W-1:0]         limit,
    output logic signed [phc_pkg::ACC_W-1:0]    acc
);
    import phc_pkg::*;

    logic signed [ACC_W-1:0]  integ_reg;
    logic signed [ACC_W-1:0]  integ_next;
    logic signed [KSUM_W-1:0] ksum;
    logic signed [KSUM_W-1:0] kadj;
    logic signed [KSUM_W-1:0] lim_s;

    // trunc((20*I + x) / 20) = k + adj with k = I + trunc(x / 20);
    // a nonzero remainder against the sign of k pulls k one step to zero.
    always_comb
    begin
        ksum  = KSUM_W'(integ_reg) + KSUM_W'(quot);
        lim_s = $signed({{(KSUM_W-LIMIT_W){1'b0}}, limit});
        kadj  = ksum;
        if (ctl.rem_nz && ctl.neg && (ksum > 0))
        begin
            kadj = ksum - KSUM_W'(1);
        end
        else if (ctl.rem_nz && !ctl.neg && (ksum < 0))
        begin
            kadj = ksum + KSUM_W'(1);
        end
        if (kadj < -lim_s)
        begin
            acc = ACC_W'(-lim_s);
        end
        else if (kadj > lim_s)
        begin
            acc = ACC_W'(lim_s);
        end
        else
        begin
            acc = ACC_W'(kadj);
        end
        integ_next = ctl.err_zero ? '0 : acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (upd)
        begin
            integ_reg <= integ_next;
        end
    end

endmodule

>>> design/pid_heading_corrector_unit.sv
// PID heading corrector, top level: handshake, pipeline stages, gains.
// Depends on phc_pkg, phc_speed_bounds and phc_integral.
//
// Fully pipelined: one request is accepted every clock cycle unless a held
// result fills the pipe; each result passes seven registers (input register,
// five arithmetic stages, output register). The rate is set by the integral
// update, a combinational add, round-fix and clamp loop that each request
// passes once; all multiplications (elapsed times error, the gains, the
// reciprocal divides by 5 and by 100) sit in stages outside that loop. Every
// stage has its own valid bit, so a stalled result only holds the stages
// behind it while they are full, and a bubble is filled as soon as a
// request arrives. A request with zero heading error clears the integral
// and repeats the last correction. Configuration writes apply in the cycle
// after cfg_we and must only be issued while the pipe is empty. After reset
// no clearing pass is needed; valid bits and control state reset at once.
module pid_heading_corrector_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  phc_pkg::cfg_idx_t                   cfg_index,
    input  logic [phc_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [phc_pkg::SPEED_W-1:0]  speed_0,
    input  logic signed [phc_pkg::SPEED_W-1:0]  speed_1,
    input  logic signed [phc_pkg::SPEED_W-1:0]  speed_2,
    input  logic signed [phc_pkg::SPEED_W-1:0]  speed_3,
    input  logic signed [phc_pkg::HEAD_W-1:0]   target,
    input  logic signed [phc_pkg::HEAD_W-1:0]   measured,
    input  logic [phc_pkg::DT_W-1:0]            elapsed_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [phc_pkg::OUT_W-1:0]    correction
);
    import phc_pkg::*;

    localparam int STAGES = 7;

    // ---------------- configuration ----------------
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   kd_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // Keep only the low bits of each register; the index space is fully used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= PROP_GAIN_RST;
            kd_reg     <= DERIV_GAIN_RST;
            limit_reg  <= LIMIT_RST;
            margin_reg <= MARGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:      kp_reg     <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:     kd_reg     <= cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_DRIVE_MARGIN:   margin_reg <= cfg_data[MARGIN_W-1:0];
                default:            kp_reg     <= kp_reg;
            endcase
        end
    end

    // ---------------- stage valids and ready chain ----------------
    // Stage k may load when it is empty or its content moves on this cycle.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] adv;

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        adv[0]        = rdy[0] && in_valid;
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            adv[k]        = rdy[k] && valid_reg[k-1];
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];

    // ---------------- stage 0: input register ----------------
    speed_t                  in_speed [MOTOR_COUNT];
    speed_t                  s0_speed_reg [MOTOR_COUNT];
    logic signed [HEAD_W-1:0] s0_target_reg;
    logic signed [HEAD_W-1:0] s0_measured_reg;
    logic [DT_W-1:0]          s0_dt_reg;

    assign in_speed[0] = speed_0;
    assign in_speed[1] = speed_1;
    assign in_speed[2] = speed_2;
    assign in_speed[3] = speed_3;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_speed_reg    <= in_speed;
            s0_target_reg   <= target;
            s0_measured_reg <= measured;
            s0_dt_reg       <= elapsed_ms;
        end
    end

    // ---------------- stage 0 -> 1: error, elapsed product, P, window ----
    logic signed [ERR_W-1:0]   s1_err_next;
    logic signed [PROD_W-1:0]  s1_prod_next;
    logic signed [PTERM_W-1:0] s1_p_next;
    logic signed [BOUND_W-1:0] s1_hi_next;
    logic signed [BOUND_W-1:0] s1_lo_next;

    assign s1_err_next  = ERR_W'(s0_target_reg) - ERR_W'(s0_measured_reg);
    assign s1_prod_next = PROD_W'($signed({1'b0, s0_dt_reg})) * PROD_W'(s1_err_next);
    assign s1_p_next    = PTERM_W'(s1_err_next) * PTERM_W'($signed({1'b0, kp_reg}));

    phc_speed_bounds u_bounds (
        .speed    (s0_speed_reg),
        .margin   (margin_reg),
        .hi_bound (s1_hi_next),
        .lo_bound (s1_lo_next)
    );

    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg;
    logic signed [PTERM_W-1:0] s1_p_reg;
    logic signed [BOUND_W-1:0] s1_hi_reg;
    logic signed [BOUND_W-1:0] s1_lo_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_err_reg  <= s1_err_next;
            s1_prod_reg <= s1_prod_next;
            s1_p_reg    <= s1_p_next;
            s1_hi_reg   <= s1_hi_next;
            s1_lo_reg   <= s1_lo_next;
        end
    end

    // ---------------- stage 1 -> 2: D term, |x| / 20 ----------------
    // Error history advances as each request leaves stage 1, in order.
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [DIFF_W-1:0]  err_diff;
    logic signed [DTERM_W-1:0] s2_d_next;
    logic signed [PROD_W-1:0]  prod_abs;
    logic [MAG_W-1:0]          s2_mag_next;
    logic [Q5_PROD_W-1:0]      q5_prod;
    logic [QUOT_W-1:0]         s2_quot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (adv[2])
        begin
            prev_err_reg <= s1_err_reg;
        end
    end

    assign err_diff  = DIFF_W'(prev_err_reg) - DIFF_W'(s1_err_reg);
    assign s2_d_next = DTERM_W'(err_diff) * DTERM_W'($signed({1'b0, kd_reg}));

    // trunc(|x| / 20) = floor(floor(|x| / 4) / 5)
    assign prod_abs     = s1_prod_reg[PROD_W-1] ? -s1_prod_reg : s1_prod_reg;
    assign s2_mag_next  = prod_abs[MAG_W-1:0];
    assign q5_prod      = Q5_PROD_W'(s2_mag_next[MAG_W-1:2]) * Q5_PROD_W'(RECIP5);
    assign s2_quot_next = q5_prod[RECIP5_SHIFT +: QUOT_W];

    logic                      s2_zero_reg;
    logic                      s2_neg_reg;
    logic [MAG_W-1:0]          s2_mag_reg;
    logic [QUOT_W-1:0]         s2_quot_reg;
    logic signed [PTERM_W-1:0] s2_p_reg;
    logic signed [DTERM_W-1:0] s2_d_reg;
    logic signed [BOUND_W-1:0] s2_hi_reg;
    logic signed [BOUND_W-1:0] s2_lo_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_zero_reg <= (s1_err_reg == '0);
            s2_neg_reg  <= s1_prod_reg[PROD_W-1];
            s2_mag_reg  <= s2_mag_next;
            s2_quot_reg <= s2_quot_next;
            s2_p_reg    <= s1_p_reg;
            s2_d_reg    <= s2_d_next;
            s2_hi_reg   <= s1_hi_reg;
            s2_lo_reg   <= s1_lo_reg;
        end
    end

    // ---------------- stage 2 -> 3: signed quotient, remainder flag -------
    logic [MAG_W-1:0]       quot_x20;
    integ_ctl_t             s3_ctl_next;
    logic signed [QX_W-1:0] s3_qx_next;

    assign quot_x20 = (MAG_W'(s2_quot_reg) << 4) + (MAG_W'(s2_quot_reg) << 2);
    assign s3_ctl_next.err_zero = s2_zero_reg;
    assign s3_ctl_next.rem_nz   = (s2_mag_reg != quot_x20);
    assign s3_ctl_next.neg      = s2_neg_reg;
    assign s3_qx_next = s2_neg_reg ? -$signed({1'b0, s2_quot_reg})
                                   :  $signed({1'b0, s2_quot_reg});

    integ_ctl_t                s3_ctl_reg;
    logic signed [QX_W-1:0]    s3_qx_reg;
    logic signed [PTERM_W-1:0] s3_p_reg;
    logic signed [DTERM_W-1:0] s3_d_reg;
    logic signed [BOUND_W-1:0] s3_hi_reg;
    logic signed [BOUND_W-1:0] s3_lo_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_ctl_reg <= s3_ctl_next;
            s3_qx_reg  <= s3_qx_next;
            s3_p_reg   <= s2_p_reg;
            s3_d_reg   <= s2_d_reg;
            s3_hi_reg  <= s2_hi_reg;
            s3_lo_reg  <= s2_lo_reg;
        end
    end

    // ---------------- stage 3 -> 4: integral update ----------------
    logic signed [ACC_W-1:0] s4_acc_next;

    phc_integral u_integral (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (adv[4]),
        .ctl   (s3_ctl_reg),
        .quot  (s3_qx_reg),
        .limit (limit_reg),
        .acc   (s4_acc_next)
    );

    logic signed [ACC_W-1:0]   s4_acc_reg;
    logic                      s4_zero_reg;
    logic signed [PTERM_W-1:0] s4_p_reg;
    logic signed [DTERM_W-1:0] s4_d_reg;
    logic signed [BOUND_W-1:0] s4_hi_reg;
    logic signed [BOUND_W-1:0] s4_lo_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_acc_reg  <= s4_acc_next;
            s4_zero_reg <= s3_ctl_reg.err_zero;
            s4_p_reg    <= s3_p_reg;
            s4_d_reg    <= s3_d_reg;
            s4_hi_reg   <= s3_hi_reg;
            s4_lo_reg   <= s3_lo_reg;
        end
    end

    // ---------------- stage 4 -> 5: integral / 100 ----------------
    logic signed [ACC_W-1:0]  acc_abs;
    logic [Q100_PROD_W-1:0]   q100_prod;
    logic [I100_W-2:0]        q100;
    logic signed [I100_W-1:0] s5_i100_next;

    assign acc_abs      = s4_acc_reg[ACC_W-1] ? -s4_acc_reg : s4_acc_reg;
    assign q100_prod    = Q100_PROD_W'(acc_abs[ACC_W-2:0]) * Q100_PROD_W'(RECIP100);
    assign q100         = q100_prod[RECIP100_SHIFT +: (I100_W-1)];
    assign s5_i100_next = s4_acc_reg[ACC_W-1] ? -$signed({1'b0, q100})
                                              :  $signed({1'b0, q100});

    logic signed [I100_W-1:0]  s5_i100_reg;
    logic                      s5_zero_reg;
    logic signed [PTERM_W-1:0] s5_p_reg;
    logic signed [DTERM_W-1:0] s5_d_reg;
    logic signed [BOUND_W-1:0] s5_hi_reg;
    logic signed [BOUND_W-1:0] s5_lo_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_i100_reg <= s5_i100_next;
            s5_zero_reg <= s4_zero_reg;
            s5_p_reg    <= s4_p_reg;
            s5_d_reg    <= s4_d_reg;
            s5_hi_reg   <= s4_hi_reg;
            s5_lo_reg   <= s4_lo_reg;
        end
    end

    // ---------------- stage 5 -> 6: combine, clamp, hold ----------------
    // High bound first; the low bound is only tried when the high one holds.
    logic signed [SUM_W-1:0] pid_sum;
    logic signed [SUM_W-1:0] hi_ext;
    logic signed [SUM_W-1:0] lo_ext;
    logic signed [SUM_W-1:0] clamped;
    logic signed [OUT_W-1:0] corr_next;
    logic signed [OUT_W-1:0] held_reg;
    logic signed [OUT_W-1:0] corr_reg;

    always_comb
    begin
        pid_sum = SUM_W'(s5_p_reg) + SUM_W'(s5_i100_reg) - SUM_W'(s5_d_reg);
        hi_ext  = SUM_W'(s5_hi_reg);
        lo_ext  = SUM_W'(s5_lo_reg);
        if (pid_sum > hi_ext)
        begin
            clamped = hi_ext;
        end
        else if (pid_sum < lo_ext)
        begin
            clamped = lo_ext;
        end
        else
        begin
            clamped = pid_sum;
        end
        corr_next = s5_zero_reg ? held_reg : OUT_W'(clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (adv[6])
        begin
            held_reg <= corr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            corr_reg <= corr_next;
        end
    end

    assign correction = corr_reg;

endmodule

>>> design/phc_checker.sv
// Port-level checker for the PID heading corrector and its bind.
// Depends on phc_pkg and pid_heading_corrector_unit_assert.svh.
`include "pid_heading_corrector_unit_assert.svh"

module phc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [phc_pkg::OUT_W-1:0]  correction
);
    import phc_pkg::*;

    // A free output side leaves every stage free to advance.
    `PHC_ASSERT_IMPL(a_ready_flow, out_ready, in_ready)

    // A stalled result holds its value.
    `PHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(correction))

    // The clamp window can never place a result beyond the widest headroom.
    `PHC_ASSERT_IMPL(a_corr_range, out_valid, (correction >= -11'sd961) && (correction <= 11'sd961))

endmodule

bind pid_heading_corrector_unit phc_checker u_phc_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_heading_corrector_unit: a directed table, then randomized
// tracking and noise requests across seven gain phases, checked against a bit-exact predictor.
// Depends on phc_pkg and the design sources of pid_heading_corrector_unit.
module tb_top;
    import phc_pkg::*;

    // One heading request, plus a hand-worked correction for the directed rows
    // where the answer is obvious from the gains at reset.
    typedef struct packed {
        logic signed [SPEED_W-1:0] s0, s1, s2, s3;
        logic signed [HEAD_W-1:0]  tgt, meas;
        logic [DT_W-1:0]           dt;
        logic                      known;
        logic signed [OUT_W-1:0]   want;
    } request_t;

    localparam int DIRECTED_ROWS    = 21;
    localparam int PHASES           = 7;
    localparam int RANDOM_PER_PHASE = 219;
    localparam int DRAIN_LIMIT      = 2000;

    // Directed rows run with the reset gains (kp 3, kd 10, limit 10000, margin 93).
    localparam request_t DIRECTED [DIRECTED_ROWS] = '{
        // zero error straight out of reset: repeat the reset correction
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'd0, 1'b1, 11'sd0},
        // largest positive error: saturate against the high bound
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd511, 10'h200, 16'd0, 1'b1, 11'sd93},
        // largest negative error: saturate against the low bound
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'h200, 10'sd511, 16'd0, 1'b1, -11'sd93},
        // zero error again: hold the last correction, clear the integral
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd5, 10'sd5, 16'd100, 1'b1, -11'sd93},
        // speeds at both range ends: bounds cross, high clamp wins and low is skipped
        '{10'sd450, -10'sd450, 10'sd0, 10'sd0, 10'sd1, 10'sd0, 16'hFFFF, 1'b1, -11'sd357},
        // speeds beyond the motor range are compared as given
        '{10'sd511, 10'h200, 10'sd0, 10'sd0, 10'sd0, 10'sd1, 16'd0, 1'b1, -11'sd418},
        // every speed below the floor: max stays at the floor
        '{10'h200, 10'h200, 10'h200, 10'h200, 10'sd100, 10'sd90, 16'hAAAA, 1'b0, 11'sd0},
        // every speed above the ceiling: min stays at the ceiling
        '{10'sd511, 10'sd511, 10'sd511, 10'sd511, -10'sd100, -10'sd90, 16'h5555, 1'b0, 11'sd0},
        // drive the integral into its positive limit and keep it there
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd511, 10'h200, 16'hFFFF, 1'b0, 11'sd0},
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd511, 10'h200, 16'hFFFF, 1'b0, 11'sd0},
        // swing it to the negative limit
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'h200, 10'sd511, 16'hFFFF, 1'b0, 11'sd0},
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'h200, 10'sd511, 16'hFFFF, 1'b0, 11'sd0},
        // negative quotients truncate toward zero
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, -10'sd7, 10'sd0, 16'd3, 1'b0, 11'sd0},
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 16'hFFFF, 1'b0, 11'sd0},
        '{10'sd100, -10'sd100, 10'sd50, -10'sd50, 10'sd3, -10'sd3, 16'd1, 1'b0, 11'sd0},
        '{-10'sd450, 10'sd450, -10'sd450, 10'sd450, -10'sd200, 10'sd200, 16'd1000, 1'b0, 11'sd0},
        // sub-unit integral steps of either sign
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd1, 10'sd0, 16'd19, 1'b0, 11'sd0},
        '{10'sd0, 10'sd0, 10'sd0, 10'sd0, -10'sd1, 10'sd0, 16'd19, 1'b0, 11'sd0},
        '{10'sd449, -10'sd449, 10'sd449, -10'sd449, -10'sd1, -10'sd1, 16'd7, 1'b0, 11'sd0},
        // alternating bit patterns on every field
        '{10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 16'h00FF, 1'b0, 11'sd0},
        '{10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 16'hFF00, 1'b0, 11'sd0}
    };

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    cfg_idx_t                  cfg_index  = CFG_PROP_GAIN;
    logic [CFG_W-1:0]          cfg_data   = '0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic signed [SPEED_W-1:0] speed_0    = '0;
    logic signed [SPEED_W-1:0] speed_1    = '0;
    logic signed [SPEED_W-1:0] speed_2    = '0;
    logic signed [SPEED_W-1:0] speed_3    = '0;
    logic signed [HEAD_W-1:0]  target     = '0;
    logic signed [HEAD_W-1:0]  measured   = '0;
    logic [DT_W-1:0]           elapsed_ms = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic signed [OUT_W-1:0]   correction;

    // Shadow of the gain registers and of the controller state.
    int kp_q, kd_q, ilim_q, margin_q;
    int integ_q, last_err_q, held_q;
    // Heading walk used to build well-formed tracking sequences.
    int trk_tgt, trk_meas;

    logic signed [OUT_W-1:0] expected_corr [$];

    int mismatches    = 0;
    int accepted      = 0;
    int delivered     = 0;
    int zero_err_seen = 0;
    int hi_clamps     = 0;
    int lo_clamps     = 0;
    int integ_sats    = 0;
    int input_stalls  = 0;

    pid_heading_corrector_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .speed_0    (speed_0),
        .speed_1    (speed_1),
        .speed_2    (speed_2),
        .speed_3    (speed_3),
        .target     (target),
        .measured   (measured),
        .elapsed_ms (elapsed_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .correction (correction)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Advance the controller shadow by one request and return its correction.
    function automatic logic signed [OUT_W-1:0] heading_step(input request_t r);
        int     spd [MOTOR_COUNT];
        int     top;
        int     bottom;
        int     err;
        longint acc;
        longint corr;
        spd[0] = r.s0;
        spd[1] = r.s1;
        spd[2] = r.s2;
        spd[3] = r.s3;
        top    = SPEED_FLOOR;
        bottom = SPEED_CEIL;
        foreach (spd[i])
        begin
            if (spd[i] < bottom)
                bottom = spd[i];
            if (top < spd[i])
                top = spd[i];
        end
        err = int'(r.tgt) - int'(r.meas);
        if (err != 0)
        begin
            acc = (20 * longint'(integ_q) + longint'(r.dt) * err) / 20;
            if (acc < -ilim_q)
            begin
                acc = -ilim_q;
                integ_sats++;
            end
            else if (acc > ilim_q)
            begin
                acc = ilim_q;
                integ_sats++;
            end
            integ_q = int'(acc);
            corr = longint'(err) * kp_q + acc / 100 - longint'(last_err_q - err) * kd_q;
            // the low bound is skipped once the high bound has fired
            if (corr > margin_q - top)
            begin
                corr = margin_q - top;
                hi_clamps++;
            end
            else if (corr < -margin_q - bottom)
            begin
                corr = -margin_q - bottom;
                lo_clamps++;
            end
            held_q = int'(corr);
        end
        else
        begin
            integ_q = 0;
            zero_err_seen++;
        end
        last_err_q = err;
        return held_q[OUT_W-1:0];
    endfunction

    // Mostly closed-loop tracking of a target that changes now and then, with
    // a share of equal headings, extremes and plain noise.
    function automatic request_t random_request();
        request_t r;
        int       step;
        r.known = 1'b0;
        r.want  = '0;
        if ($urandom_range(0, 7) == 0)
        begin
            r.s0 = SPEED_W'($urandom());
            r.s1 = SPEED_W'($urandom());
            r.s2 = SPEED_W'($urandom());
            r.s3 = SPEED_W'($urandom());
        end
        else
        begin
            r.s0 = SPEED_W'(int'($urandom_range(0, 900)) - 450);
            r.s1 = SPEED_W'(int'($urandom_range(0, 900)) - 450);
            r.s2 = SPEED_W'(int'($urandom_range(0, 900)) - 450);
            r.s3 = SPEED_W'(int'($urandom_range(0, 900)) - 450);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                if ((trk_tgt == trk_meas && $urandom_range(0, 3) == 0) ||
                    $urandom_range(0, 39) == 0)
                    trk_tgt = int'($urandom_range(0, 1023)) - 512;
                step     = (trk_tgt - trk_meas) / 4 + int'($urandom_range(0, 6)) - 3;
                trk_meas = trk_meas + step;
                if (trk_meas > 511)
                    trk_meas = 511;
                if (trk_meas < -512)
                    trk_meas = -512;
                r.tgt  = HEAD_W'(trk_tgt);
                r.meas = HEAD_W'(trk_meas);
            end
            6:
            begin
                r.tgt  = HEAD_W'($urandom());
                r.meas = r.tgt;
            end
            7:
            begin
                r.tgt  = $urandom_range(0, 1) ? HEAD_W'(511) : HEAD_W'(-512);
                r.meas = $urandom_range(0, 1) ? HEAD_W'(511) : HEAD_W'(-512);
            end
            default:
            begin
                r.tgt  = HEAD_W'($urandom());
                r.meas = HEAD_W'($urandom());
            end
        endcase
        case ($urandom_range(0, 7))
            0:       r.dt = '0;
            1:       r.dt = '1;
            2:       r.dt = DT_W'($urandom());
            default: r.dt = DT_W'($urandom_range(1, 40));
        endcase
        return r;
    endfunction

    // Write one register and mirror it in the shadow; the caller drops cfg_we.
    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PROP_GAIN:      kp_q     = int'(value[GAIN_W-1:0]);
            CFG_DERIV_GAIN:     kd_q     = int'(value[GAIN_W-1:0]);
            CFG_INTEGRAL_LIMIT: ilim_q   = int'(value[LIMIT_W-1:0]);
            CFG_DRIVE_MARGIN:   margin_q = int'(value[MARGIN_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_gains(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] kd,
                              input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] margin);
        cfg_write(CFG_PROP_GAIN, kp);
        cfg_write(CFG_DERIV_GAIN, kd);
        cfg_write(CFG_INTEGRAL_LIMIT, lim);
        cfg_write(CFG_DRIVE_MARGIN, margin);
        cfg_we <= 1'b0;
    endtask

    // Offer one request, hold it until taken, then queue its correction.
    // Called right after a rising edge.
    task automatic offer_request(input request_t r);
        int                      gap;
        logic signed [OUT_W-1:0] predicted;
        // every 256 requests, send a burst of back-to-back requests
        gap = (accepted % 256 < 40) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        speed_0    <= r.s0;
        speed_1    <= r.s1;
        speed_2    <= r.s2;
        speed_3    <= r.s3;
        target     <= r.tgt;
        measured   <= r.meas;
        elapsed_ms <= r.dt;
        @(posedge clk);
        while (!in_ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        accepted++;
        // always step the shadow so its state stays in line with the block
        predicted = heading_step(r);
        expected_corr.push_back(r.known ? r.want : predicted);
    endtask

    // Result side: stall at random, with calm stretches and two long hold-offs
    // that fill the pipe and must push back on the request side.
    initial
    begin : result_sink
        int                      stall;
        logic signed [OUT_W-1:0] want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (delivered == 150 || delivered == 900)
                stall = 80;
            else if ((delivered + 128) % 256 < 40)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            delivered++;
            if (expected_corr.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with nothing pending (correction %0d)",
                                        delivered, correction));
            else
            begin
                want = expected_corr.pop_front();
                if (correction !== want)
                    flag_mismatch($sformatf("result %0d: correction %0d, expected %0d",
                                            delivered, correction, want));
            end
        end
    end

    initial
    begin : stimulus
        int waited;
        int row;
        int phase;
        kp_q       = PROP_GAIN_RST;
        kd_q       = DERIV_GAIN_RST;
        ilim_q     = LIMIT_RST;
        margin_q   = MARGIN_RST;
        integ_q    = 0;
        last_err_q = 0;
        held_q     = 0;
        trk_tgt    = 0;
        trk_meas   = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_request(DIRECTED[row]);

        // Phase 0 keeps the reset gains; every later phase reloads all four
        // registers once the pipe has drained.
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                in_valid <= 1'b0;
                while (expected_corr.size() != 0)
                    @(posedge clk);
                case (phase)
                    1: load_gains('0, '0, '0, '0);
                    2: load_gains('1, '1, '1, '1);
                    3, 4: load_gains(CFG_W'($urandom()), CFG_W'($urandom()),
                                     CFG_W'($urandom()), CFG_W'($urandom()));
                    5: load_gains(15'h7F01, 15'h0080, 15'd1, 15'h0100);
                    default: load_gains(CFG_W'(PROP_GAIN_RST), CFG_W'(DERIV_GAIN_RST),
                                        CFG_W'(LIMIT_RST), CFG_W'(MARGIN_RST));
                endcase
            end
            repeat (RANDOM_PER_PHASE)
                offer_request(random_request());
        end

        // Drain, then idle past the pipe latency to catch any stray result.
        in_valid <= 1'b0;
        waited = 0;
        while (expected_corr.size() != 0 && waited < DRAIN_LIMIT)
        begin
            waited++;
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (expected_corr.size() != 0)
            flag_mismatch($sformatf("%0d corrections never arrived", expected_corr.size()));

        $display("Ran %0d requests over %0d gain sets: %0d zero-error holds, %0d clipped integrals,",
                 accepted, PHASES, zero_err_seen, integ_sats);
        $display("%0d high-side and %0d low-side clamps, %0d cycles of request backpressure.",
                 hi_clamps, lo_clamps, input_stalls);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #5_000_000;
        $display("Timed out: %0d accepted, %0d delivered, %0d pending",
                 accepted, delivered, expected_corr.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/phc_pkg.sv
design/phc_speed_bounds.sv
design/phc_integral.sv
design/pid_heading_corrector_unit.sv
design/phc_checker.sv
sim/tb_top.sv
